### hw/rtl/babd_pkg.sv
// ----------------------------------------------------------------------------
// babd_pkg
// Shared types and constants of the best anchor box decoder.
// ----------------------------------------------------------------------------
package babd_pkg;

	localparam int ANCHOR_COUNT_DEF = 896;

	// first grid: 16x16 cells, 2 anchors each; second grid: 8x8 cells, 6 each
	localparam int GRID1_COUNT    = 512;
	localparam int GRID1_CELL_W   = 8;
	localparam int GRID1_SIDE_W   = 4;
	localparam int GRID1_SHIFT    = 6;
	localparam int GRID2_PER_CELL = 6;
	localparam int GRID2_SUB_W    = 3;
	localparam int GRID2_CELL_W   = 6;
	localparam int GRID2_SIDE_W   = 3;
	localparam int GRID2_SHIFT    = 7;

	// anchor centre, 1/2048 image units
	localparam int CTR_W = 11;

	localparam int FRAME_Q_DEPTH = 2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int DIM_W       = 12;
	localparam int SCORE_W     = 16;
	localparam int SCALE_W     = 10;
	localparam int FIELD_W     = 16;

	localparam logic [DIM_W-1:0]           IMAGE_WIDTH_RST     = 12'd640;
	localparam logic [DIM_W-1:0]           IMAGE_HEIGHT_RST    = 12'd480;
	localparam logic signed [SCORE_W-1:0]  SCORE_THRESHOLD_RST = 16'sd281;
	localparam logic [SCALE_W-1:0]         BOX_SCALE_RST       = 10'd371;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_WIDTH     = 2'd0,
		REG_IMAGE_HEIGHT    = 2'd1,
		REG_SCORE_THRESHOLD = 2'd2,
		REG_BOX_SCALE       = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [DIM_W-1:0]          image_width;
		logic [DIM_W-1:0]          image_height;
		logic signed [SCORE_W-1:0] score_threshold;
		logic [SCALE_W-1:0]        box_scale;
	} cfg_t;

	// winning anchor of one frame
	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [CTR_W-1:0]          anchor_y;
		logic [CTR_W-1:0]          anchor_x;
		logic signed [FIELD_W-1:0] offset_y;
		logic signed [FIELD_W-1:0] offset_x;
		logic signed [FIELD_W-1:0] size_h;
		logic signed [FIELD_W-1:0] size_w;
	} frame_t;

endpackage

### hw/rtl/best_anchor_box_decode.sv
// ----------------------------------------------------------------------------
// best_anchor_box_decode
// Picks the best scoring anchor of each frame and decodes its box to a
// square, image clipped pixel box.
// ----------------------------------------------------------------------------
// One anchor is accepted every clock cycle while full is low. The intake
// keeps a running maximum with a single compare per item; on the anchor
// marked last it hands the frame winner to a two-entry queue. The box
// decoder works one winner at a time: a detected box passes the edge,
// multiply, max, scale, square and clip steps, a miss goes from the edge
// step to the output step, and both wait there for the previous result
// to be popped. full rises only while two finished frames wait for the decoder.
// Configuration registers are read while a result is made; write them
// only while the block is idle.
module best_anchor_box_decode #(
	parameter int ANCHOR_COUNT = babd_pkg::ANCHOR_COUNT_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [babd_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [babd_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   push,
	output logic                                   full,
	input  logic signed [babd_pkg::SCORE_W-1:0]    score,
	input  logic signed [babd_pkg::FIELD_W-1:0]    offset_y,
	input  logic signed [babd_pkg::FIELD_W-1:0]    offset_x,
	input  logic signed [babd_pkg::FIELD_W-1:0]    size_h,
	input  logic signed [babd_pkg::FIELD_W-1:0]    size_w,
	input  logic                                   last_anchor,
	output logic                                   empty,
	input  logic                                   pop,
	output logic [15:0]                            box_left,
	output logic [15:0]                            box_top,
	output logic [15:0]                            box_width,
	output logic [15:0]                            box_height,
	output logic                                   detected
);

	babd_pkg::cfg_t   cfg_q;
	logic             frame_push;
	babd_pkg::frame_t frame_in;
	babd_pkg::frame_t frame_head;
	logic             frame_pop;
	logic             frame_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= babd_pkg::IMAGE_WIDTH_RST;
			cfg_q.image_height    <= babd_pkg::IMAGE_HEIGHT_RST;
			cfg_q.score_threshold <= babd_pkg::SCORE_THRESHOLD_RST;
			cfg_q.box_scale       <= babd_pkg::BOX_SCALE_RST;
		end else if (cfg_we) begin
			case (babd_pkg::reg_index_t'(cfg_index))
				babd_pkg::REG_IMAGE_WIDTH:
					cfg_q.image_width <= cfg_data[babd_pkg::DIM_W-1:0];
				babd_pkg::REG_IMAGE_HEIGHT:
					cfg_q.image_height <= cfg_data[babd_pkg::DIM_W-1:0];
				babd_pkg::REG_SCORE_THRESHOLD:
					cfg_q.score_threshold <= signed'(cfg_data[babd_pkg::SCORE_W-1:0]);
				babd_pkg::REG_BOX_SCALE:
					cfg_q.box_scale <= cfg_data[babd_pkg::SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	babd_front #(
		.ANCHOR_COUNT(ANCHOR_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.score      (score),
		.offset_y   (offset_y),
		.offset_x   (offset_x),
		.size_h     (size_h),
		.size_w     (size_w),
		.last_anchor(last_anchor),
		.frame_push (frame_push),
		.frame_data (frame_in)
	);

	babd_frame_q u_frame_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (frame_push),
		.wr_data(frame_in),
		.rd_en  (frame_pop),
		.rd_data(frame_head),
		.q_full (full),
		.q_empty(frame_empty)
	);

	babd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.frame_head (frame_head),
		.frame_empty(frame_empty),
		.frame_pop  (frame_pop),
		.empty      (empty),
		.pop        (pop),
		.box_left   (box_left),
		.box_top    (box_top),
		.box_width  (box_width),
		.box_height (box_height),
		.detected   (detected)
	);

endmodule

### hw/rtl/babd_front.sv
// ----------------------------------------------------------------------------
// babd_front
// Anchor intake: tracks the anchor position, keeps the running best and
// hands the winner of each frame to the frame queue.
// ----------------------------------------------------------------------------
module babd_front #(
	parameter int ANCHOR_COUNT = babd_pkg::ANCHOR_COUNT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic                                 full,
	input  logic signed [babd_pkg::SCORE_W-1:0]  score,
	input  logic signed [babd_pkg::FIELD_W-1:0]  offset_y,
	input  logic signed [babd_pkg::FIELD_W-1:0]  offset_x,
	input  logic signed [babd_pkg::FIELD_W-1:0]  size_h,
	input  logic signed [babd_pkg::FIELD_W-1:0]  size_w,
	input  logic                                 last_anchor,
	output logic                                 frame_push,
	output babd_pkg::frame_t                     frame_data
);

	localparam int CNT_W = $clog2(ANCHOR_COUNT);

	logic [CNT_W-1:0]                    cnt_q;
	logic [babd_pkg::GRID2_SUB_W-1:0]    sub_q;
	logic [babd_pkg::GRID2_CELL_W-1:0]   cell_q;
	logic                                have_q;
	babd_pkg::frame_t                    best_q;

	logic                                accept;
	logic                                take;
	logic [babd_pkg::GRID1_CELL_W-1:0]   cell1;
	logic [babd_pkg::CTR_W-1:0]          ax;
	logic [babd_pkg::CTR_W-1:0]          ay;
	babd_pkg::frame_t                    cur;

	assign accept = push && !full;
	assign cell1  = cnt_q[babd_pkg::GRID1_CELL_W:1];

	always_comb begin
		if (cnt_q < CNT_W'(babd_pkg::GRID1_COUNT)) begin
			ax = babd_pkg::CTR_W'({cell1[babd_pkg::GRID1_SIDE_W-1:0], 1'b1})
				<< babd_pkg::GRID1_SHIFT;
			ay = babd_pkg::CTR_W'({cell1[babd_pkg::GRID1_CELL_W-1:babd_pkg::GRID1_SIDE_W],
				1'b1}) << babd_pkg::GRID1_SHIFT;
		end else begin
			ax = babd_pkg::CTR_W'({cell_q[babd_pkg::GRID2_SIDE_W-1:0], 1'b1})
				<< babd_pkg::GRID2_SHIFT;
			ay = babd_pkg::CTR_W'({cell_q[babd_pkg::GRID2_CELL_W-1:babd_pkg::GRID2_SIDE_W],
				1'b1}) << babd_pkg::GRID2_SHIFT;
		end
	end

	always_comb begin
		cur.score    = score;
		cur.anchor_y = ay;
		cur.anchor_x = ax;
		cur.offset_y = offset_y;
		cur.offset_x = offset_x;
		cur.size_h   = size_h;
		cur.size_w   = size_w;
	end

	// earliest wins ties: replace only on a strictly higher score
	assign take       = !have_q || (score > best_q.score);
	assign frame_push = accept && last_anchor;
	assign frame_data = take ? cur : best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sub_q  <= '0;
			cell_q <= '0;
			have_q <= 1'b0;
		end else if (accept) begin
			if (last_anchor) begin
				cnt_q  <= '0;
				sub_q  <= '0;
				cell_q <= '0;
				have_q <= 1'b0;
			end else begin
				if (take)
					have_q <= 1'b1;
				// saturate on the last anchor position
				if (cnt_q < CNT_W'(ANCHOR_COUNT - 1)) begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q >= CNT_W'(babd_pkg::GRID1_COUNT)) begin
						if (sub_q == babd_pkg::GRID2_SUB_W'(babd_pkg::GRID2_PER_CELL - 1)) begin
							sub_q  <= '0;
							cell_q <= cell_q + 1'b1;
						end else begin
							sub_q <= sub_q + 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !last_anchor && take)
			best_q <= cur;
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ANCHOR_COUNT - 1))
		else $error("anchor counter past the last anchor");

	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q < babd_pkg::GRID2_SUB_W'(babd_pkg::GRID2_PER_CELL))
		else $error("second grid sub-index out of range");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		frame_push |=> (cnt_q == '0) && !have_q)
		else $error("frame state not cleared after last anchor");
`endif

endmodule

### hw/rtl/babd_frame_q.sv
// ----------------------------------------------------------------------------
// babd_frame_q
// Short queue of frame winners between the intake and the box decoder.
// ----------------------------------------------------------------------------
module babd_frame_q (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  babd_pkg::frame_t wr_data,
	input  logic             rd_en,
	output babd_pkg::frame_t rd_data,
	output logic             q_full,
	output logic             q_empty
);

	localparam int DEPTH = babd_pkg::FRAME_Q_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	babd_pkg::frame_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign q_full  = (count_q == CNT_W'(DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && q_full))
		else $error("frame winner dropped on a full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("frame queue count out of range");
`endif

endmodule

### hw/rtl/babd_back.sv
// ----------------------------------------------------------------------------
// babd_back
// Box decoder: turns one frame winner into a pixel box over a few steps
// of a small sequencer and holds the result until it is popped.
// ----------------------------------------------------------------------------
module babd_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  babd_pkg::cfg_t             cfg,
	input  babd_pkg::frame_t           frame_head,
	input  logic                       frame_empty,
	output logic                       frame_pop,
	output logic                       empty,
	input  logic                       pop,
	output logic [15:0]                box_left,
	output logic [15:0]                box_top,
	output logic [15:0]                box_width,
	output logic [15:0]                box_height,
	output logic                       detected
);

	localparam int EDGE_W = 13;
	localparam int SUM_W  = 19;
	localparam int PIX_W  = 24;
	localparam int PSUM_W = 25;
	localparam int MS_W   = 34;
	localparam int SQ_W   = 36;
	localparam int LIN_W  = 34;
	localparam int RND_W  = 35;
	localparam int Q_W    = 18;
	localparam int LIM_SHIFT = 21;
	localparam int RND_SHIFT = 17;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE,
		ST_MUL,
		ST_MAX,
		ST_SCALE,
		ST_SQUARE,
		ST_CLIP,
		ST_OUT
	} state_t;

	function automatic logic [EDGE_W-1:0] clamp_unit(input logic signed [SUM_W-1:0] e);
		logic [EDGE_W-1:0] r;
		if (e < 0)
			r = '0;
		else if (e > SUM_W'(4096))
			r = EDGE_W'(4096);
		else
			r = e[EDGE_W-1:0];
		return r;
	endfunction

	function automatic logic [2*LIN_W-1:0] clip_axis(
		input logic signed [SQ_W-1:0] lo,
		input logic signed [SQ_W-1:0] hi,
		input logic [babd_pkg::DIM_W-1:0] dim
	);
		logic signed [SQ_W-1:0] lim;
		logic signed [SQ_W-1:0] lo_c;
		logic signed [SQ_W-1:0] hi_c;
		lim  = signed'(SQ_W'(dim) << LIM_SHIFT);
		lo_c = (lo < 0) ? '0 : lo;
		hi_c = (hi > lim) ? lim : hi;
		if (hi_c < lo_c)
			hi_c = lo_c;
		return {lo_c[LIN_W-1:0], hi_c[LIN_W-1:0]};
	endfunction

	function automatic logic [Q_W-1:0] round_px(input logic [LIN_W-1:0] v);
		logic [RND_W-1:0] s;
		s = RND_W'(v) + RND_W'(65536);
		return Q_W'(s >> RND_SHIFT);
	endfunction

	state_t                  state_q;
	logic                    out_valid_q;
	babd_pkg::frame_t        frm_q;
	logic                    det_q;
	logic [EDGE_W-1:0]       ex1_q, ex2_q, ey1_q, ey2_q;
	logic [PIX_W-1:0]        px1_q, px2_q, py1_q, py2_q;
	logic [PIX_W-1:0]        m_q;
	logic [PSUM_W-1:0]       sx_q, sy_q;
	logic [MS_W-1:0]         ms_q;
	logic signed [SQ_W-1:0]  lox_q, hix_q, loy_q, hiy_q;
	logic [LIN_W-1:0]        lxc_q, hxc_q, lyc_q, hyc_q;

	logic signed [SUM_W-1:0] cx2, cy2;
	logic [PIX_W-1:0]        bw, bh;
	logic [2*LIN_W-1:0]      clip_x, clip_y;
	logic [Q_W-1:0]          lx_r, hx_r, ly_r, hy_r;
	logic                    out_free;

	assign frame_pop = (state_q == ST_IDLE) && !frame_empty;
	assign empty     = !out_valid_q;
	assign out_free  = !out_valid_q || pop;

	always_comb begin
		cx2 = (SUM_W'(frm_q.offset_x) + signed'(SUM_W'(frm_q.anchor_x))) <<< 1;
		cy2 = (SUM_W'(frm_q.offset_y) + signed'(SUM_W'(frm_q.anchor_y))) <<< 1;
		bw  = (px2_q > px1_q) ? px2_q - px1_q : '0;
		bh  = (py2_q > py1_q) ? py2_q - py1_q : '0;
		clip_x = clip_axis(lox_q, hix_q, cfg.image_width);
		clip_y = clip_axis(loy_q, hiy_q, cfg.image_height);
		lx_r = round_px(lxc_q);
		hx_r = round_px(hxc_q);
		ly_r = round_px(lyc_q);
		hy_r = round_px(hyc_q);
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			box_left    <= '0;
			box_top     <= '0;
			box_width   <= '0;
			box_height  <= '0;
			detected    <= 1'b0;
		end else begin
			// a pop in the output state is followed by a reload below
			if (pop && out_valid_q && (state_q != ST_OUT))
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!frame_empty)
						state_q <= ST_EDGE;
				end
				ST_EDGE: begin
					state_q <= (frm_q.score >= cfg.score_threshold) ? ST_MUL : ST_OUT;
				end
				ST_MUL:    state_q <= ST_MAX;
				ST_MAX:    state_q <= ST_SCALE;
				ST_SCALE:  state_q <= ST_SQUARE;
				ST_SQUARE: state_q <= ST_CLIP;
				ST_CLIP:   state_q <= ST_OUT;
				ST_OUT: begin
					// hold until the result slot is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						detected    <= det_q;
						if (det_q) begin
							box_left   <= lx_r[15:0];
							box_top    <= ly_r[15:0];
							box_width  <= 16'(hx_r - lx_r);
							box_height <= 16'(hy_r - ly_r);
						end else begin
							box_left   <= '0;
							box_top    <= '0;
							box_width  <= '0;
							box_height <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!frame_empty)
					frm_q <= frame_head;
			end
			ST_EDGE: begin
				det_q <= (frm_q.score >= cfg.score_threshold);
				ex1_q <= clamp_unit(cx2 - SUM_W'(frm_q.size_w));
				ex2_q <= clamp_unit(cx2 + SUM_W'(frm_q.size_w));
				ey1_q <= clamp_unit(cy2 - SUM_W'(frm_q.size_h));
				ey2_q <= clamp_unit(cy2 + SUM_W'(frm_q.size_h));
			end
			ST_MUL: begin
				px1_q <= PIX_W'(ex1_q) * PIX_W'(cfg.image_width);
				px2_q <= PIX_W'(ex2_q) * PIX_W'(cfg.image_width);
				py1_q <= PIX_W'(ey1_q) * PIX_W'(cfg.image_height);
				py2_q <= PIX_W'(ey2_q) * PIX_W'(cfg.image_height);
			end
			ST_MAX: begin
				m_q  <= (bw > bh) ? bw : bh;
				sx_q <= PSUM_W'(px1_q) + PSUM_W'(px2_q);
				sy_q <= PSUM_W'(py1_q) + PSUM_W'(py2_q);
			end
			ST_SCALE: begin
				ms_q <= MS_W'(m_q) * MS_W'(cfg.box_scale);
			end
			ST_SQUARE: begin
				lox_q <= signed'({3'b000, sx_q, 8'h00}) - signed'(SQ_W'(ms_q));
				hix_q <= signed'({3'b000, sx_q, 8'h00}) + signed'(SQ_W'(ms_q));
				loy_q <= signed'({3'b000, sy_q, 8'h00}) - signed'(SQ_W'(ms_q));
				hiy_q <= signed'({3'b000, sy_q, 8'h00}) + signed'(SQ_W'(ms_q));
			end
			ST_CLIP: begin
				lxc_q <= clip_x[2*LIN_W-1:LIN_W];
				hxc_q <= clip_x[LIN_W-1:0];
				lyc_q <= clip_y[2*LIN_W-1:LIN_W];
				hyc_q <= clip_y[LIN_W-1:0];
			end
			default: begin
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !detected |-> (box_left == '0) && (box_top == '0) &&
			(box_width == '0) && (box_height == '0))
		else $error("undetected result carries a box");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && out_valid_q && !pop |=> (state_q == ST_OUT))
		else $error("result slot overwritten before it was popped");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		frame_pop |=> (state_q == ST_EDGE))
		else $error("frame taken without starting the decode");
`endif

endmodule

### tb/best_anchor_box_decode_tb.sv
// ----------------------------------------------------------------------------
// best_anchor_box_decode_tb
// Streams anchor frames through the decoder and checks every box it returns.
// A scoreboard tracks the running best anchor of each frame and decodes the
// winner to the expected square pixel box when the frame's last anchor is
// accepted. Both queue sides idle at random, and the registers are changed
// between phases, including their extreme values.
// ----------------------------------------------------------------------------
module best_anchor_box_decode_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import babd_pkg::*;

	typedef struct packed {
		shortint score;
		shortint offset_y;
		shortint offset_x;
		shortint size_h;
		shortint size_w;
		bit      last_mark;
	} anchor_t;

	typedef struct packed {
		bit [15:0] left;
		bit [15:0] top;
		bit [15:0] wide;
		bit [15:0] tall;
		bit        detected;
	} box_t;

	class frame_box_tracker;
		int img_w = IMAGE_WIDTH_RST;
		int img_h = IMAGE_HEIGHT_RST;
		int thr   = SCORE_THRESHOLD_RST;
		int scale = BOX_SCALE_RST;

		int   slot;
		int   best_score;
		int   best_slot;
		int   best_off[4];
		bit   have_best;
		box_t pending_boxes[$];
		int   errors;

		function void set_reg(reg_index_t idx, int value);
			case (idx)
				REG_IMAGE_WIDTH:     img_w = value & 'hFFF;
				REG_IMAGE_HEIGHT:    img_h = value & 'hFFF;
				REG_SCORE_THRESHOLD: thr = shortint'(value);
				REG_BOX_SCALE:       scale = value & 'h3FF;
				default: ;
			endcase
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10)
				$display("[%0t] %s", $time, msg);
		endfunction

		function longint unit_clamp(longint e);
			if (e < 0)
				return 0;
			if (e > 4096)
				return 4096;
			return e;
		endfunction

		// p1, p2 in 1/4096 px; the square edges are exact in 1/2^21 px
		function void square_axis(longint p1, longint p2, longint ms, int dim,
				output bit [15:0] lo_q, output bit [15:0] size_q);
			longint lo, hi, lim, l, h;
			lo = (p1 + p2) * 256 - ms;
			hi = (p1 + p2) * 256 + ms;
			lim = longint'(dim) * 2097152;
			if (lo < 0)
				lo = 0;
			if (hi > lim)
				hi = lim;
			if (hi < lo)
				hi = lo;
			l = (lo + 65536) >>> 17;
			h = (hi + 65536) >>> 17;
			lo_q = l[15:0];
			size_q = 16'(h - l);
		endfunction

		function void take_anchor(anchor_t a);
			box_t   b;
			int     grid_pos;
			longint ax, ay, cx, cy, x1, x2, y1, y2, bw, bh, m;
			if (!have_best || a.score > best_score) begin
				best_score = a.score;
				best_slot = slot;
				best_off = '{a.offset_y, a.offset_x, a.size_h, a.size_w};
				have_best = 1'b1;
			end
			// hold at the last anchor once the frame runs long
			if (slot < ANCHOR_COUNT_DEF - 1)
				slot++;
			if (!a.last_mark)
				return;
			b = '0;
			if (best_score >= thr) begin
				if (best_slot < GRID1_COUNT) begin
					grid_pos = (best_slot >> 1) & 255;
					ax = (2 * (grid_pos & 15) + 1) * 64;
					ay = (2 * (grid_pos >> 4) + 1) * 64;
				end else begin
					grid_pos = ((best_slot - GRID1_COUNT) / GRID2_PER_CELL) & 63;
					ax = (2 * (grid_pos & 7) + 1) * 128;
					ay = (2 * (grid_pos >> 3) + 1) * 128;
				end
				cy = best_off[0] + ay;
				cx = best_off[1] + ax;
				x1 = unit_clamp(2 * cx - best_off[3]) * img_w;
				x2 = unit_clamp(2 * cx + best_off[3]) * img_w;
				y1 = unit_clamp(2 * cy - best_off[2]) * img_h;
				y2 = unit_clamp(2 * cy + best_off[2]) * img_h;
				bw = (x2 > x1) ? x2 - x1 : 0;
				bh = (y2 > y1) ? y2 - y1 : 0;
				m = (bw > bh) ? bw : bh;
				square_axis(x1, x2, m * scale, img_w, b.left, b.wide);
				square_axis(y1, y2, m * scale, img_h, b.top, b.tall);
				b.detected = 1'b1;
			end
			pending_boxes.push_back(b);
			slot = 0;
			have_best = 1'b0;
			best_score = 0;
			best_slot = 0;
			best_off = '{0, 0, 0, 0};
		endfunction

		function void match_box(box_t got);
			box_t want;
			if (pending_boxes.size() == 0) begin
				report($sformatf("box L=%0d T=%0d W=%0d H=%0d D=%0d with no frame pending",
					got.left, got.top, got.wide, got.tall, got.detected));
				return;
			end
			want = pending_boxes.pop_front();
			if (got.left != want.left || got.top != want.top || got.wide != want.wide ||
					got.tall != want.tall || got.detected != want.detected)
				report($sformatf("box mismatch: expected L=%0d T=%0d W=%0d H=%0d D=%0d, got L=%0d T=%0d W=%0d H=%0d D=%0d",
					want.left, want.top, want.wide, want.tall, want.detected,
					got.left, got.top, got.wide, got.tall, got.detected));
		endfunction

		function void flush_leftovers();
			while (pending_boxes.size() != 0) begin
				void'(pending_boxes.pop_front());
				report("expected box never returned");
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;
	logic                      push = 1'b0;
	logic                      full;
	logic signed [SCORE_W-1:0] score = '0;
	logic signed [FIELD_W-1:0] offset_y = '0;
	logic signed [FIELD_W-1:0] offset_x = '0;
	logic signed [FIELD_W-1:0] size_h = '0;
	logic signed [FIELD_W-1:0] size_w = '0;
	logic                      last_anchor = 1'b0;
	logic                      empty;
	logic                      pop = 1'b0;
	logic [15:0]               box_left, box_top, box_width, box_height;
	logic                      detected;

	frame_box_tracker tracker = new;
	int send_calm = 0;
	int take_calm = 0;

	best_anchor_box_decode dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full),
		.score(score), .offset_y(offset_y), .offset_x(offset_x),
		.size_h(size_h), .size_w(size_w), .last_anchor(last_anchor),
		.empty(empty), .pop(pop),
		.box_left(box_left), .box_top(box_top), .box_width(box_width),
		.box_height(box_height), .detected(detected)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int draw_wait(ref int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0) begin
			calm = $urandom_range(8, 64);
			return 0;
		end
		return $urandom_range(0, 6);
	endfunction

	function automatic anchor_t anchor_of(int s, int oy, int ox, int sh, int sw, bit last_mark);
		anchor_t a;
		a = '{shortint'(s), shortint'(oy), shortint'(ox), shortint'(sh), shortint'(sw), last_mark};
		return a;
	endfunction

	// mostly plausible detections around the threshold, the rest raw noise
	function automatic anchor_t make_anchor(bit last_mark);
		int s;
		if ($urandom_range(0, 3) == 0) begin
			s = $urandom;
			if ($urandom_range(0, 7) == 0)
				s = $urandom_range(0, 1) ? 32767 : -32768;
			return anchor_of(s, $urandom, $urandom, $urandom, $urandom, last_mark);
		end
		s = tracker.thr + int'($urandom_range(0, 1535)) - 1024;
		if (s > 32767)
			s = 32767;
		if (s < -32768)
			s = -32768;
		return anchor_of(s, int'($urandom_range(0, 512)) - 256, int'($urandom_range(0, 512)) - 256,
			$urandom_range(0, 3000), $urandom_range(0, 3000), last_mark);
	endfunction

	task automatic send_anchor(anchor_t a);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			@(negedge clk) push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		score <= a.score;
		offset_y <= a.offset_y;
		offset_x <= a.offset_x;
		size_h <= a.size_h;
		size_w <= a.size_w;
		last_anchor <= a.last_mark;
		do @(posedge clk); while (full !== 1'b0);
		tracker.take_anchor(a);
	endtask

	// drop push and wait until every frame's box is back and the decoder is quiet
	task automatic drain();
		@(negedge clk) push <= 1'b0;
		while (tracker.pending_boxes.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[15:0];
		@(negedge clk) cfg_we <= 1'b0;
		tracker.set_reg(idx, value);
	endtask

	task automatic configure(int w, int h, int thr, int scale);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_SCORE_THRESHOLD, thr);
		write_reg(REG_BOX_SCALE, scale);
	endtask

	task automatic run_phase(int phase_no, int budget);
		int      sent, len, peak, twin;
		anchor_t a;
		sent = 0;
		if (phase_no == 0) begin
			// one full-length or overlong frame: reaches the second grid and, when overlong, the held last index
			len = ANCHOR_COUNT_DEF + $urandom_range(0, 6);
			peak = $urandom_range(500, len - 1);
			twin = $urandom_range(peak, len - 1);
			for (int i = 0; i < len; i++) begin
				a = make_anchor(i == len - 1);
				a.score = (i == peak || i == twin) ? 30000 :
					shortint'(int'($urandom_range(0, 20000)) - 30000);
				send_anchor(a);
			end
		end
		while (sent < budget) begin
			len = ($urandom_range(0, 6) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
			for (int i = 0; i < len; i++)
				send_anchor(make_anchor(i == len - 1));
			sent += len;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// single-anchor frames at the score extremes and around the threshold
		send_anchor(anchor_of(32767, 0, 0, 0, 0, 1));
		send_anchor(anchor_of(-32768, 100, 100, 100, 100, 1));
		send_anchor(anchor_of(281, 0, 0, 512, 512, 1));
		send_anchor(anchor_of(280, 0, 0, 512, 512, 1));
		// equal scores: the earlier anchor wins
		send_anchor(anchor_of(100, 1, 2, 3, 4, 0));
		send_anchor(anchor_of(300, 10, 20, 800, 600, 0));
		send_anchor(anchor_of(300, -5, -5, 100, 100, 0));
		send_anchor(anchor_of(50, 7, 7, 7, 7, 1));
		// offset extremes, negative sizes, clipping on both sides
		send_anchor(anchor_of(1000, 32767, -32768, 32767, -32768, 1));
		send_anchor(anchor_of(1000, -32768, 32767, -32768, 32767, 1));
		send_anchor(anchor_of(1000, -1, -1, -1, -1, 1));
		send_anchor(anchor_of(1000, 0, 0, 4000, 2000, 1));
		send_anchor(anchor_of(-1, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 0));
		send_anchor(anchor_of(2000, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 1));
		drain();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: ;
				1: configure(4095, 4095, -32768, 1023);
				2: configure(1, 1, 32767, 0);
				3: configure(0, 0, 0, 256);
				default: configure($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535));
			endcase
			run_phase(p, 130);
			drain();
		end

		repeat (40) @(posedge clk);
		tracker.flush_leftovers();
		if (tracker.errors == 0)
			$display("** best_anchor_box_decode: PASSED **");
		else
			$display("** best_anchor_box_decode: FAILED **");
		$finish;
	end

	initial begin
		box_t got;
		int   stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(take_calm);
			if (stall > 0) begin
				@(negedge clk) pop <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
			got = '{box_left, box_top, box_width, box_height, detected};
			tracker.match_box(got);
		end
	end

	initial begin
		#2ms;
		$display("** best_anchor_box_decode: FAILED **");
		$finish;
	end

endmodule

### files.f
hw/rtl/babd_pkg.sv
hw/rtl/babd_front.sv
hw/rtl/babd_frame_q.sv
hw/rtl/babd_back.sv
hw/rtl/best_anchor_box_decode.sv
tb/best_anchor_box_decode_tb.sv
